[hw/rtl/ped_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the percent-escape decoder.
// No dependencies; imported by percent_escape_decoder_core.
package ped_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;
    localparam int SLOTS       = 3;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    typedef logic [COUNT_WIDTH-1:0] tally_t;

    localparam tally_t TALLY_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] total;
        logic                   endf;
        logic                   validf;
        logic [7:0]             data;
    } res_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end
        return h;
    endfunction

    function automatic tally_t sat_add(input tally_t t, input logic [1:0] inc);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, t} + (COUNT_WIDTH + 1)'(inc);
        if (sum > {1'b0, TALLY_MAX})
        begin
            return TALLY_MAX;
        end
        return sum[COUNT_WIDTH-1:0];
    endfunction

endpackage

[hw/rtl/percent_escape_decoder_core.sv]
`timescale 1ns / 1ps
// Streaming URI percent-decoder: escape tracking, error tally and a small
// result queue. Depends on ped_pkg.
//
//  channel   dir  tdata                                   tuser       tlast
//  s_axis    in   [7:0] in_byte                           -           in_last
//  m_axis    out  [7:0] out_byte, [23:8] error_total      out_valid   out_end
//
// One beat is decoded in the cycle it is accepted; its results are registered
// into a three-entry queue and can leave it in the next cycle at the earliest.
// s_axis_tready is high while the queue holds at most one result, so one beat
// per cycle is taken while results drain; two results from a beat stall input.
// Reset clears escape state, tally and queue; no clearing pass is needed.
// Downstream stalls back up into the queue and then into s_axis_tready.
module percent_escape_decoder_core
    import ped_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] error_total
    output logic        m_axis_tuser,   // [0] out_valid
    output logic        m_axis_tlast
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    tally_t      tally_reg, tally_next, tally_bumped;
    logic [1:0]  bumps;
    logic [1:0]  count_reg, count_next;
    res_t        slot_reg [SLOTS];
    res_t        slot_next [SLOTS];
    res_t        shifted [SLOTS];

    logic        s_fire, pop;
    logic [7:0]  c;
    logic        last, is_pct;
    hex_t        hex_c, hex_held;
    logic [7:0]  pair;
    logic        pair_ok;
    res_t        r0, r1;
    logic [1:0]  n_res;
    logic [1:0]  base;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign c        = s_axis_tdata;
    assign last     = s_axis_tlast;
    assign is_pct   = (c == PCT_CHAR);
    assign hex_c    = hex_decode(c);
    assign hex_held = hex_decode(held_reg);
    assign pair     = {hex_held.val, hex_c.val};
    assign pair_ok  = hex_held.ok && hex_c.ok && (pair != 8'd0);

    // next escape state and error bumps
    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        bumps      = 2'd0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                bumps      = {1'b0, is_pct && last};
                phase_next = (is_pct && !last) ? PH_PCT : PH_IDLE;
            end
            PH_PCT:
            begin
                if (!last && hex_c.ok)
                begin
                    held_next  = c;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    bumps      = 2'd1 + {1'b0, is_pct && last};
                    phase_next = (is_pct && !last) ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT:
            begin
                if (!pair_ok)
                begin
                    bumps      = 2'd1 + {1'b0, is_pct && last};
                    phase_next = (is_pct && !last) ? PH_PCT : PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (last)
        begin
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    assign tally_bumped = sat_add(tally_reg, bumps);
    assign tally_next   = last ? '0 : tally_bumped;

    // result beats for the accepted input
    always_comb
    begin
        r0    = '0;
        r1    = '0;
        n_res = 2'd0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!is_pct)
                begin
                    r0.data = c;
                    n_res   = 2'd1;
                end
            end
            PH_PCT:
            begin
                if (!(!last && hex_c.ok) && !is_pct)
                begin
                    r0.data = c;
                    n_res   = 2'd1;
                end
            end
            PH_DIGIT:
            begin
                if (pair_ok)
                begin
                    r0.data = pair;
                    n_res   = 2'd1;
                end
                else
                begin
                    r0.data = held_reg;
                    n_res   = 2'd1;
                    if (!is_pct)
                    begin
                        r1.data = c;
                        n_res   = 2'd2;
                    end
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        r0.validf = (n_res != 2'd0);
        r1.validf = (n_res == 2'd2);
        if (last)
        begin
            if (n_res == 2'd2)
            begin
                r1.endf  = 1'b1;
                r1.total = TOTAL_WIDTH'(tally_bumped);
            end
            else
            begin
                r0.endf  = 1'b1;
                r0.total = TOTAL_WIDTH'(tally_bumped);
                n_res    = 2'd1;
            end
        end
        if (!s_fire)
        begin
            n_res = 2'd0;
        end
    end

    // result queue: advance on pop, append new beats behind the survivors
    always_comb
    begin
        shifted[0] = slot_reg[1];
        shifted[1] = slot_reg[2];
        shifted[2] = slot_reg[2];
        base       = count_reg - {1'b0, pop};
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = pop ? shifted[i] : slot_reg[i];
            if (n_res != 2'd0 && base == 2'(i))
            begin
                slot_next[i] = r0;
            end
            if (n_res == 2'd2 && (base + 2'd1) == 2'(i))
            begin
                slot_next[i] = r1;
            end
        end
        count_next = base + n_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
            tally_reg <= '0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_fire)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                tally_reg <= tally_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign s_axis_tready = (count_reg <= 2'd1);
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {slot_reg[0].total, slot_reg[0].data};
    assign m_axis_tuser  = slot_reg[0].validf;
    assign m_axis_tlast  = slot_reg[0].endf;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> (phase_reg == PH_IDLE && tally_reg == '0))
        else $error("escape state not cleared after final beat");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty result beat that is not the final one");

    a_total_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("error total on a non-final beat");

    a_held_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGIT) |-> hex_held.ok)
        else $error("held digit is not a hex digit");

endmodule
